/* rtl/sad_descriptor_ratio_matcher_assert.svh */
// Assertion macros for the descriptor matcher.
`ifndef SAD_DESCRIPTOR_RATIO_MATCHER_ASSERT_SVH
`define SAD_DESCRIPTOR_RATIO_MATCHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srm assertion failed");
`define SRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srm assertion failed");
`else
`define SRM_ASSERT_SAME(lbl, ante, cons)
`define SRM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/srm_pkg.sv */
// Shared types and constants of the descriptor matcher.
package srm_pkg;
  localparam logic [1:0] OP_WR_BYTE = 2'd0;
  localparam logic [1:0] OP_WR_ID   = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;
  localparam logic [1:0] OP_FRAME   = 2'd3;

  localparam logic [1:0] REG_ENTRIES = 2'd0;
  localparam logic [1:0] REG_MAXDIST = 2'd1;
  localparam logic [1:0] REG_RATIO   = 2'd2;

  localparam int DIST_W = 15;
  localparam logic [DIST_W-1:0] NO_DIST = 15'h7FFF;
  localparam logic [DIST_W-1:0] MAXDIST_RST = 15'd32640;
  localparam logic [3:0] RATIO_RST = 4'd8;
  localparam logic [18:0] RATIO_SCALE = 19'd10;
  localparam logic [7:0] STAMP_WRAP = 8'hFF;

  typedef struct packed {
    logic       shift;
    logic       wr;
    logic [6:0] pos;
    logic [7:0] data;
  } qctl_t;
endpackage

/* rtl/srm_qcell.sv */
// One query byte cell of the rotating query ring.
module srm_qcell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  srm_pkg::qctl_t ctl,
  input  logic [7:0]    nb,
  output logic [7:0]    q
);
  import srm_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.shift) begin
      byte_nxt = nb;
    end else if (ctl.wr && ctl.pos == 7'(IDX)) begin
      byte_nxt = ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign q = byte_r;
endmodule

/* rtl/sad_descriptor_ratio_matcher.sv */
// Brute-force SAD descriptor matcher with ratio test: top level.
// Input stream: tuser = operation, tlast = end of query, tdata carries
// entry, position and value. Operations 0/1/3 and non-final query bytes
// give no result. A final query byte starts a scan of min(entries_in_use,
// ENTRIES) entries, one descriptor byte per cycle from the descriptor
// memory, while the query ring of DESC_LEN cells rotates in step. The
// scan is followed by the drain, decide and result states (zero entries
// go straight to decide) before out_tvalid rises; in_tready is low from
// the cycle after acceptance until the result is loaded. The output register holds
// one result; if the receiver stalls, a finished query waits until the
// register frees, then the block goes back to accepting requests.
// Reset clears the configuration to its defaults, the frame stamp and all
// match stamps (per-entry valid bits), and empties the output register.
// Descriptor, id and query contents are not cleared.
// APB: entries_in_use at 0x0, max_distance at 0x4, ratio_limit at 0x8.
module sad_descriptor_ratio_matcher #(
  parameter int DESC_LEN = 128,
  parameter int ENTRIES  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // entry[7:0], position[14:8], value[22:15]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // matched[0], object_id[7:1], best_dist[22:8]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import srm_pkg::*;

  localparam int EW = $clog2(ENTRIES);
  localparam int CW = EW + 1;
  localparam int PW = (DESC_LEN > 1) ? $clog2(DESC_LEN) : 1;
  localparam int AW = $clog2(ENTRIES * DESC_LEN) > 0 ? $clog2(ENTRIES * DESC_LEN) : 1;
  localparam logic [AW-1:0] DL_A = AW'(DESC_LEN);
  localparam logic [PW-1:0] P_LAST = PW'(DESC_LEN - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_RES = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [8:0] ent_r;
  logic [DIST_W-1:0] maxd_r;
  logic [3:0] lim_r;
  logic [7:0] frame_r;
  logic [ENTRIES-1:0] vld_r;
  logic [CW-1:0] cnt_r, cnt_c;
  logic [EW-1:0] e_r;
  logic [PW-1:0] p_r;

  logic [7:0] desc_mem [ENTRIES*DESC_LEN];
  logic [6:0] id_mem [ENTRIES];
  logic [7:0] stamp_mem [ENTRIES];
  logic [7:0] a_rd_r, stamp_rd_r;
  logic [6:0] id_rd_r;

  logic s1_vld_r, s1_first_r, s1_last_r, s1_sv_r;
  logic [EW-1:0] s1_e_r;
  logic [7:0] s1_q_r;
  logic [DIST_W-1:0] acc_r, best_r, sec_r;
  logic hb_r, hs_r;
  logic [EW-1:0] bidx_r;
  logic ok_r;

  logic out_tvalid_r;
  logic [23:0] out_tdata_r;

  logic acc_in, cfg_wr;
  logic [1:0] op;
  logic [7:0] in_entry, in_value;
  logic [6:0] in_pos;
  logic ent_ok, pos_ok;
  logic [AW-1:0] wr_addr, rd_addr;

  qctl_t qctl;
  logic [7:0] ring [DESC_LEN];

  logic [7:0] diff;
  logic [DIST_W-1:0] sum;
  logic elig;
  logic [18:0] prod_b, prod_s;
  logic ok_c;

  assign op       = in_tuser;
  assign in_entry = in_tdata[7:0];
  assign in_pos   = in_tdata[14:8];
  assign in_value = in_tdata[22:15];
  assign acc_in   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign ent_ok   = {1'b0, in_entry} < 9'(ENTRIES);
  assign pos_ok   = {1'b0, in_pos} < 8'(DESC_LEN);
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cnt_c    = (ent_r > 9'(ENTRIES)) ? CW'(ENTRIES) : CW'(ent_r);

  always_comb begin
    case (cfg_paddr[3:2])
      REG_ENTRIES: cfg_prdata = {23'd0, ent_r};
      REG_MAXDIST: cfg_prdata = {17'd0, maxd_r};
      REG_RATIO:   cfg_prdata = {28'd0, lim_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r  <= 9'd0;
      maxd_r <= MAXDIST_RST;
      lim_r  <= RATIO_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_ENTRIES: ent_r  <= cfg_pwdata[8:0];
        REG_MAXDIST: maxd_r <= cfg_pwdata[14:0];
        REG_RATIO:   lim_r  <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // query ring
  assign qctl.shift = (state_r == S_SCAN);
  assign qctl.wr    = acc_in && op == OP_QUERY && pos_ok;
  assign qctl.pos   = in_pos;
  assign qctl.data  = in_value;

  for (genvar i = 0; i < DESC_LEN; i++) begin : g_ring
    srm_qcell #(.IDX(i)) u_cell (
      .clk (clk),
      .ctl (qctl),
      .nb  (ring[(i + 1) % DESC_LEN]),
      .q   (ring[i])
    );
  end

  // memories
  assign wr_addr = AW'(AW'(in_entry[EW-1:0]) * DL_A) + AW'(in_pos[PW-1:0]);
  assign rd_addr = AW'(AW'(e_r) * DL_A) + AW'(p_r);

  always_ff @(posedge clk) begin
    if (acc_in && op == OP_WR_BYTE && ent_ok && pos_ok) begin
      desc_mem[wr_addr] <= in_value;
    end
    a_rd_r <= desc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (acc_in && op == OP_WR_ID && ent_ok) begin
      id_mem[in_entry[EW-1:0]] <= in_value[6:0];
    end
    id_rd_r <= id_mem[bidx_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE && ok_c) begin
      stamp_mem[bidx_r] <= frame_r;
    end
    stamp_rd_r <= stamp_mem[e_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      frame_r <= 8'd0;
    end else if (acc_in && op == OP_FRAME) begin
      if (frame_r == STAMP_WRAP) begin
        vld_r   <= '0;
        frame_r <= 8'd1;
      end else begin
        frame_r <= frame_r + 8'd1;
      end
    end else if (state_r == S_DECIDE && ok_c) begin
      vld_r[bidx_r] <= 1'b1;
    end
  end

  // accumulate and rank
  assign diff = (a_rd_r > s1_q_r) ? a_rd_r - s1_q_r : s1_q_r - a_rd_r;
  assign sum  = (s1_first_r ? '0 : acc_r) + DIST_W'(diff);
  assign elig = (s1_sv_r ? stamp_rd_r : 8'd0) != frame_r;

  always_ff @(posedge clk) begin
    s1_first_r <= (p_r == '0);
    s1_last_r  <= (p_r == P_LAST);
    s1_e_r     <= e_r;
    s1_q_r     <= ring[0];
    s1_sv_r    <= vld_r[e_r];
    if (s1_vld_r) begin
      acc_r <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      hb_r     <= 1'b0;
      hs_r     <= 1'b0;
    end else begin
      s1_vld_r <= (state_r == S_SCAN);
      if (acc_in && op == OP_QUERY && in_tlast) begin
        hb_r <= 1'b0;
        hs_r <= 1'b0;
      end else if (s1_vld_r && s1_last_r && elig && (!hs_r || sum < sec_r)) begin
        if (!hb_r || sum < best_r) begin
          if (hb_r) begin
            sec_r <= best_r;
            hs_r  <= 1'b1;
          end
          best_r <= sum;
          bidx_r <= s1_e_r;
          hb_r   <= 1'b1;
        end else begin
          sec_r <= sum;
          hs_r  <= 1'b1;
        end
      end
    end
  end

  // floor(10*best/second) > limit  <=>  10*best >= (limit+1)*second
  assign prod_b = 19'(best_r) * RATIO_SCALE;
  assign prod_s = 19'(sec_r) * 19'({1'b0, lim_r} + 5'd1);
  assign ok_c = hb_r && best_r <= maxd_r &&
                !(hs_r && (sec_r == '0 || prod_b >= prod_s));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc_in && op == OP_QUERY && in_tlast) begin
          state_nxt = (cnt_c == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (p_r == P_LAST && {1'b0, e_r} == cnt_r - CW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_RES;
      S_RES: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      e_r     <= '0;
      p_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) begin
        e_r   <= '0;
        p_r   <= '0;
        cnt_r <= cnt_c;
      end else if (state_r == S_SCAN) begin
        if (p_r == P_LAST) begin
          p_r <= '0;
          e_r <= e_r + EW'(1);
        end else begin
          p_r <= p_r + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE) begin
      ok_r <= ok_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_RES && (!out_tvalid_r || out_tready)) begin
      out_tvalid_r <= 1'b1;
      out_tdata_r  <= {1'b0, (hb_r ? best_r : NO_DIST),
                       (ok_r ? id_rd_r : 7'd0), ok_r};
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `include "sad_descriptor_ratio_matcher_assert.svh"

  `SRM_ASSERT_SAME(a_scan_range, state_r == S_SCAN, {1'b0, e_r} < cnt_r)
  `SRM_ASSERT_NEXT(a_frame_nonzero, acc_in && op == OP_FRAME, frame_r != 8'd0)
  `SRM_ASSERT_SAME(a_unmatched_id, out_tvalid_r && !out_tdata_r[0], out_tdata_r[7:1] == 7'd0)
endmodule
